/* rtl/core/lzfb_pkg.sv */
// Package: shared constants and types for the LZ flag-byte stream decoder.
package lzfb_pkg;
	localparam int HISTORY_DEPTH_DEF    = 4096;
	localparam int BYTES_PER_RESULT_DEF = 8;
	localparam int HEADER_LEN           = 16;
	localparam logic [7:0] FLAG_MSB     = 8'h80;
	localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
	localparam logic [8:0] LONG_LEN_ADD = 9'h012;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_BADREF = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        last;
		logic [1:0]  status;
	} out_item_t;
endpackage

/* rtl/core/lzfb_if.sv */
// Interface: valid/ready channel carrying one payload.
interface lzfb_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lz_flag_byte_stream_decoder_core.sv */
// Top level: streaming LZ flag-byte (Yaz0 style) decompressor.
//
// Usage: compressed bytes arrive on in_ch (in_byte, last_in), one per
// transaction; decoded bytes leave on out_ch, packed up to BYTES_PER_RESULT
// per transaction, first byte in bits 7:0. The first 16 bytes form the
// header; bytes 4..7 give the big-endian decoded size.
// Flow: every input byte passes the accept, finish and turnaround states
// (S_IDLE, S_FIN, S_WAIT); bytes after the end of a stream skip the finish.
// A byte that starts a back-reference enters S_COPY first, which primes the
// history read and copies through the single read port of the history RAM
// (4096 bytes by default, registered read data; one read per cycle while the
// output has space; a distance-one copy takes the last byte written from a bypass).
// One input byte is handled at a time; a new byte is taken once every
// result of the previous one has entered the output register.
// Output: a result is loaded into the output register when the next byte
// is decoded or at the finish, and is offered from that register.
// Reset clears all control state; the history RAM is not cleared and needs
// no clearing pass since only bytes written by the current stream are read.
// When the receiver stalls, the full output register holds and decoding
// waits; the input side stays stalled until space returns.
// Errors: early end of input (status 1) and a reference before output start
// (status 2) end the stream; later bytes are dropped until last_in.
module lz_flag_byte_stream_decoder_core #(
	parameter int HISTORY_DEPTH    = lzfb_pkg::HISTORY_DEPTH_DEF,
	parameter int BYTES_PER_RESULT = lzfb_pkg::BYTES_PER_RESULT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	lzfb_if.sink   in_ch,
	lzfb_if.source out_ch
);
	import lzfb_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(BYTES_PER_RESULT + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_COPY = 4'b0010,
		S_FIN  = 4'b0100,
		S_WAIT = 4'b1000
	} state_t;

	logic [7:0] hist_mem [HISTORY_DEPTH];
	logic [7:0] rd_data;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          wr_en;
	logic [7:0]    wr_data;

	state_t     state_q;
	logic [AW-1:0] write_pos_q;
	logic [4:0]  header_count_q;
	logic [31:0] total_size_q;
	logic [31:0] produced_q;
	logic [7:0]  flag_bits_q;
	logic [3:0]  flags_left_q;
	logic [1:0]  token_phase_q;
	logic [7:0]  b1_q;
	logic [7:0]  b2_q;
	logic        done_q;

	// copy engine
	logic [AW-1:0] dist_q;
	logic [8:0]    copy_left_q;
	logic          rd_pend_q;
	logic          last_in_q;
	logic [1:0]    fin_status_q;

	// packing accumulator; a full word waits here until the next byte or the finish
	logic [63:0]   acc_q;
	logic [CW-1:0] acc_n_q;

	// output register
	logic          ov_q;
	out_item_t     od_q;

	logic out_free;
	assign out_free = !ov_q || out_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.data  = od_q;
	assign in_ch.ready  = (state_q == S_IDLE) && out_free;

	always_ff @(posedge clk) begin
		if (wr_en) hist_mem[write_pos_q] <= wr_data;
		if (rd_en) rd_data <= hist_mem[rd_addr];
	end

	// decode of current input byte
	logic [7:0] b;
	logic       li;
	logic       take;
	assign b    = in_ch.data.in_byte;
	assign li   = in_ch.data.last_in;
	assign take = in_ch.valid && in_ch.ready;

	logic [11:0] dist_full;
	logic [8:0]  req_len;
	logic        start_copy;
	logic [31:0] remain;
	logic [8:0]  clip_len;
	always_comb begin
		dist_full  = 12'd0;
		req_len    = 9'd0;
		start_copy = 1'b0;
		if (!done_q && header_count_q == 5'(HEADER_LEN) && flags_left_q != 4'd0 &&
		    (flag_bits_q & FLAG_MSB) == 8'd0) begin
			if (token_phase_q == 2'd1 && b1_q[7:4] != 4'd0) begin
				dist_full  = {b1_q[3:0], b};
				req_len    = {5'd0, b1_q[7:4]} + 9'd2;
				start_copy = 1'b1;
			end else if (token_phase_q == 2'd2) begin
				dist_full  = {b1_q[3:0], b2_q};
				req_len    = {1'b0, b} + LONG_LEN_ADD;
				start_copy = 1'b1;
			end
		end
		remain   = total_size_q - produced_q;
		clip_len = (32'(req_len) > remain) ? remain[8:0] : req_len;
	end

	logic bad_ref;
	logic go_copy;
	assign bad_ref = (32'(dist_full) + 32'd1 > produced_q);
	assign go_copy = start_copy && !bad_ref && (clip_len != 9'd0);

	// byte emitted into accumulator this cycle
	logic       put_v;
	logic [7:0] put_b;
	logic [AW-1:0] src_addr;
	logic       fwd;
	logic [7:0] last_wr_q;
	logic       last_wr_v_q;

	// once data is flowing, the byte written this cycle advances the source too
	assign src_addr = write_pos_q - dist_q + AW'(rd_pend_q);
	assign fwd = (dist_q == AW'(1)) && last_wr_v_q;

	always_comb begin
		put_v = 1'b0;
		put_b = 8'd0;
		if (take && !done_q && header_count_q == 5'(HEADER_LEN) &&
		    flags_left_q != 4'd0 && flag_bits_q[7]) begin
			put_v = 1'b1;
			put_b = b;
		end else if (state_q == S_COPY && rd_pend_q && out_free) begin
			put_v = 1'b1;
			put_b = fwd ? last_wr_q : rd_data;
		end
	end
	assign wr_en   = put_v;
	assign wr_data = put_b;
	assign rd_en   = (state_q == S_COPY) && out_free;
	assign rd_addr = src_addr;

	logic [31:0] prod_next;
	assign prod_next = produced_q + 32'(put_v);

	// output register load: a full word pushed out by the next byte, or the finish
	logic      ov_load;
	out_item_t od_next;
	always_comb begin
		ov_load = 1'b0;
		od_next = od_q;
		if (put_v && acc_n_q == CW'(BYTES_PER_RESULT)) begin
			ov_load            = 1'b1;
			od_next.out_bytes  = acc_q;
			od_next.byte_count = 4'(BYTES_PER_RESULT);
			od_next.last       = 1'b0;
			od_next.status     = ST_OK;
		end else if (state_q == S_FIN && out_free &&
		             (acc_n_q != '0 || done_q || last_in_q)) begin
			ov_load            = 1'b1;
			od_next.out_bytes  = acc_q;
			od_next.byte_count = 4'(acc_n_q);
			od_next.last       = done_q || last_in_q;
			od_next.status     = done_q ? fin_status_q :
			                     (last_in_q ? ST_SHORT : ST_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			write_pos_q <= '0;
			header_count_q <= '0;
			total_size_q <= '0;
			produced_q <= '0;
			flag_bits_q <= '0;
			flags_left_q <= '0;
			token_phase_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			done_q <= 1'b0;
			dist_q <= '0;
			copy_left_q <= '0;
			rd_pend_q <= 1'b0;
			last_in_q <= 1'b0;
			fin_status_q <= '0;
			acc_q <= '0;
			acc_n_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
			last_wr_q <= '0;
			last_wr_v_q <= 1'b0;
		end else begin
			if (ov_load) begin
				ov_q <= 1'b1;
				od_q <= od_next;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			if (put_v) begin
				write_pos_q <= write_pos_q + AW'(1);
				produced_q  <= prod_next;
				last_wr_q   <= put_b;
				last_wr_v_q <= 1'b1;
				if (acc_n_q == CW'(BYTES_PER_RESULT)) begin
					// full word leaves, this byte opens the next one
					acc_q   <= 64'(put_b);
					acc_n_q <= CW'(1);
				end else begin
					acc_q   <= acc_q | (64'(put_b) << (8 * acc_n_q));
					acc_n_q <= acc_n_q + CW'(1);
				end
				if (prod_next == total_size_q) done_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						last_in_q    <= li;
						fin_status_q <= ST_OK;
						if (done_q) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= go_copy ? S_COPY : S_FIN;
							if (header_count_q != 5'(HEADER_LEN)) begin
								if (header_count_q >= 5'd4 && header_count_q < 5'd8)
									total_size_q <= {total_size_q[23:0], b};
								header_count_q <= header_count_q + 5'd1;
								if (header_count_q == 5'(HEADER_LEN - 1) &&
								    total_size_q == 32'd0) begin
									done_q <= 1'b1;
								end
							end else if (flags_left_q == 4'd0) begin
								flag_bits_q   <= b;
								flags_left_q  <= 4'd8;
								token_phase_q <= 2'd0;
							end else if (flag_bits_q[7]) begin
								flag_bits_q   <= {flag_bits_q[6:0], 1'b0};
								flags_left_q  <= flags_left_q - 4'd1;
								token_phase_q <= 2'd0;
							end else if (token_phase_q == 2'd0) begin
								b1_q <= b;
								token_phase_q <= 2'd1;
							end else begin
								if (token_phase_q == 2'd1) b2_q <= b;
								if (start_copy) begin
									flag_bits_q   <= {flag_bits_q[6:0], 1'b0};
									flags_left_q  <= flags_left_q - 4'd1;
									token_phase_q <= 2'd0;
									if (bad_ref) begin
										fin_status_q <= ST_BADREF;
										done_q <= 1'b1;
									end else if (clip_len != 9'd0) begin
										dist_q      <= AW'(dist_full) + AW'(1);
										copy_left_q <= clip_len;
										rd_pend_q   <= 1'b0;
										last_wr_v_q <= 1'b0;
									end
								end else begin
									token_phase_q <= 2'd2;
								end
							end
						end
					end
				end
				S_COPY: begin
					if (out_free) begin
						// a read issues each cycle; data arrives next cycle
						if (rd_pend_q) copy_left_q <= copy_left_q - 9'd1;
						if (rd_pend_q && copy_left_q == 9'd1) begin
							rd_pend_q <= 1'b0;
							state_q   <= S_FIN;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						acc_q   <= '0;
						acc_n_q <= '0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (last_in_q) begin
						write_pos_q <= '0;
						header_count_q <= '0;
						total_size_q <= '0;
						produced_q <= '0;
						flag_bits_q <= '0;
						flags_left_q <= '0;
						token_phase_q <= '0;
						b1_q <= '0;
						b2_q <= '0;
						done_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
